// File: rtl/core/tr_pkg.sv
// ============================================================================
// tr_pkg
// Shared types and constants for the tunnel reassembler.
// ============================================================================
package tr_pkg;

    localparam int MSG_BYTES   = 60;
    localparam int REASM_BYTES = 64;
    localparam int FRAME_BYTES = 64;

    localparam int BYTE_W  = 8;
    localparam int ADDR7_W = 7;
    localparam int ID_W    = 15;
    localparam int FLEN_W  = 7;

    localparam int POS_W  = $clog2(MSG_BYTES + 1);
    localparam int LEN_W  = $clog2(REASM_BYTES + 1);
    localparam int SUM_W  = $clog2(REASM_BYTES + MSG_BYTES + 1);
    localparam int CNT_W  = $clog2(FRAME_BYTES + 1);
    localparam int ADDR_W = $clog2(REASM_BYTES);

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [BYTE_W-1:0] ADDR_MASK = 8'h7F;

    localparam logic REG_EXP_PROTO = 1'b0;
    localparam logic REG_EXP_CHAN  = 1'b1;

    localparam logic [BYTE_W-1:0] EXP_PROTO_RST = 8'hFF;
    localparam logic [BYTE_W-1:0] EXP_CHAN_RST  = 8'h00;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

endpackage

// File: rtl/core/tr_ram.sv
// ============================================================================
// tr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module tr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/tunnel_reassembler_to_canfd.sv
// ============================================================================
// tunnel_reassembler_to_canfd
// Reassembles tunnel messages, one byte per transfer, into CAN-FD frames.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one message byte per transfer, tdata carries the
// byte, protocol code and channel number, tlast marks the final byte. Byte 0
// is the source, byte 1 the destination, the rest is payload kept in a
// 64-byte reassembly RAM. Bytes are taken one per cycle while no frame is read out.
// Output stream (m_axis): one transfer per frame byte with the frame id,
// frame length and tlast on the final byte; an empty frame gives one transfer
// with length 0. A short message that completes a frame stalls the input
// while the frame is read out of the RAM, one byte per cycle while the receiver
// takes every byte: each byte passes the RAM read register and then the output
// register, and an empty frame goes straight to the output register.
// The output register lets the input run while the last result waits.
// A stalled receiver holds the output transfer and halts the RAM read-out.
// Registers (APB): expected protocol at 0x0, expected channel at 0x4.
// Reset (synchronous, active low) clears positions, lengths and handshakes;
// the reassembly RAM is not cleared and is only read where written.
// ============================================================================
module tunnel_reassembler_to_canfd
    import tr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // {channel_number, protocol_code, data_byte} from the MSB down
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tlast,
    output logic                 s_axis_tready,
    // {pad, frame_byte, frame_len, frame_id} from the MSB down
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tvalid,
    output logic                 m_axis_tlast,
    input  logic                 m_axis_tready,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    t_state r_state, n_state;

    logic [BYTE_W-1:0]  r_exp_proto, r_exp_chan;
    logic [POS_W-1:0]   r_msg_pos, n_msg_pos;
    logic [BYTE_W-1:0]  r_msg_src, n_msg_src;
    logic [BYTE_W-1:0]  r_msg_dst, n_msg_dst;
    logic [ADDR7_W-1:0] r_frame_src, n_frame_src;
    logic [ADDR7_W-1:0] r_frame_dst, n_frame_dst;
    logic [LEN_W-1:0]   r_committed, n_committed;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [ID_W-1:0]    r_fid, n_fid;
    logic               r_fv, n_fv;
    logic               r_f_last, n_f_last;
    logic               r_ov, n_ov;
    logic [ID_W-1:0]    r_o_id;
    logic [FLEN_W-1:0]  r_o_len;
    logic [BYTE_W-1:0]  r_o_byte;
    logic               r_o_last;

    logic [BYTE_W-1:0]  in_byte, in_proto, in_chan;
    logic               in_eom, in_fire;
    logic               pos_lt;
    logic [POS_W-1:0]   msg_len;
    logic [SUM_W-1:0]   wr_idx, payload, sum;
    logic               wr_en;
    logic [BYTE_W-1:0]  dst_now;
    logic               msg_ok, overflow, start_emit;
    logic [ADDR7_W-1:0] id_src, id_dst;
    logic [CNT_W-1:0]   frame_n;
    logic               out_ok, rd_en, move, zero_load, load;
    logic [BYTE_W-1:0]  ram_q;
    logic               cfg_wr;

    // ---------------- configuration ----------------
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EXP_CHAN) ? PDATA_W'(r_exp_chan)
                                               : PDATA_W'(r_exp_proto);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_proto <= EXP_PROTO_RST;
            r_exp_chan  <= EXP_CHAN_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_EXP_PROTO: r_exp_proto <= pwdata[BYTE_W-1:0];
                REG_EXP_CHAN:  r_exp_chan  <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input message path ----------------
    assign in_byte  = s_axis_tdata[7:0];
    assign in_proto = s_axis_tdata[15:8];
    assign in_chan  = s_axis_tdata[23:16];
    assign in_eom   = s_axis_tlast;
    assign in_fire  = s_axis_tvalid && s_axis_tready;

    assign pos_lt  = r_msg_pos < POS_W'(MSG_BYTES);
    assign msg_len = pos_lt ? r_msg_pos + POS_W'(1) : r_msg_pos;
    assign wr_idx  = SUM_W'(r_committed) + SUM_W'(r_msg_pos) - SUM_W'(2);
    assign wr_en   = in_fire && pos_lt && (r_msg_pos >= POS_W'(2))
                     && (wr_idx < SUM_W'(REASM_BYTES));
    assign dst_now = (r_msg_pos == POS_W'(1)) ? in_byte : r_msg_dst;

    assign msg_ok = in_eom && (msg_len >= POS_W'(2))
                    && (in_proto == r_exp_proto) && (in_chan == r_exp_chan);

    assign payload = SUM_W'(msg_len) - SUM_W'(2)
                     - ((msg_len == POS_W'(MSG_BYTES)) ? SUM_W'(1) : SUM_W'(0));
    assign sum      = SUM_W'(r_committed) + payload;
    assign overflow = sum > SUM_W'(REASM_BYTES);
    assign start_emit = in_fire && msg_ok && !overflow
                        && (msg_len < POS_W'(MSG_BYTES));
    assign frame_n  = (sum > SUM_W'(FRAME_BYTES)) ? CNT_W'(FRAME_BYTES) : CNT_W'(sum);

    assign id_src = (r_committed == '0) ? r_msg_src[ADDR7_W-1:0] & ADDR_MASK[ADDR7_W-1:0]
                                        : r_frame_src;
    assign id_dst = (r_committed == '0) ? dst_now[ADDR7_W-1:0] & ADDR_MASK[ADDR7_W-1:0]
                                        : r_frame_dst;

    // ---------------- read-out path ----------------
    assign out_ok    = !r_ov || m_axis_tready;
    assign move      = r_fv && out_ok;
    assign zero_load = (r_state == ST_EMIT) && (r_n == '0) && out_ok;
    assign load      = move || zero_load;

    tr_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(REASM_BYTES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_idx[ADDR_W-1:0]),
        .i_wdata(in_byte),
        .i_re   (rd_en),
        .i_raddr(ADDR_W'(r_cnt)),
        .o_rdata(ram_q)
    );

    // ---------------- FSM ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start_emit) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if ((move && r_f_last) || zero_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_EMIT: rd_en = (r_cnt != r_n) && (!r_fv || out_ok);
            default: ;
        endcase
    end

    // ---------------- next state of datapath ----------------
    always_comb begin
        n_msg_pos   = r_msg_pos;
        n_msg_src   = r_msg_src;
        n_msg_dst   = r_msg_dst;
        n_frame_src = r_frame_src;
        n_frame_dst = r_frame_dst;
        n_committed = r_committed;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_fid       = r_fid;
        n_fv        = r_fv;
        n_f_last    = r_f_last;
        n_ov        = r_ov;

        if (in_fire) begin
            if (r_msg_pos == '0) begin
                n_msg_src = in_byte;
            end
            if (r_msg_pos == POS_W'(1)) begin
                n_msg_dst = in_byte;
            end
            n_msg_pos = msg_len;
            if (in_eom) begin
                n_msg_pos = '0;
                if (msg_ok) begin
                    n_frame_src = id_src;
                    n_frame_dst = id_dst;
                    if (overflow || start_emit) begin
                        n_committed = '0;
                    end else begin
                        n_committed = LEN_W'(sum);
                    end
                end
            end
        end

        if (start_emit) begin
            n_n   = frame_n;
            n_cnt = '0;
            n_fid = {id_src, 1'b0, id_dst};
        end

        // advance the read-out
        if (rd_en) begin
            n_cnt    = r_cnt + CNT_W'(1);
            n_f_last = (r_cnt + CNT_W'(1)) == r_n;
            n_fv     = 1'b1;
        end else if (move) begin
            n_fv = 1'b0;
        end

        if (load) begin
            n_ov = 1'b1;
        end else if (m_axis_tready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_msg_pos   <= '0;
            r_msg_src   <= '0;
            r_msg_dst   <= '0;
            r_frame_src <= '0;
            r_frame_dst <= '0;
            r_committed <= '0;
            r_n         <= '0;
            r_cnt       <= '0;
            r_fid       <= '0;
            r_fv        <= 1'b0;
            r_f_last    <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_msg_pos   <= n_msg_pos;
            r_msg_src   <= n_msg_src;
            r_msg_dst   <= n_msg_dst;
            r_frame_src <= n_frame_src;
            r_frame_dst <= n_frame_dst;
            r_committed <= n_committed;
            r_n         <= n_n;
            r_cnt       <= n_cnt;
            r_fid       <= n_fid;
            r_fv        <= n_fv;
            r_f_last    <= n_f_last;
            r_ov        <= n_ov;
        end
    end

    // output holding register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_id   <= r_fid;
            r_o_len  <= FLEN_W'(r_n);
            r_o_byte <= move ? ram_q : '0;
            r_o_last <= move ? r_f_last : 1'b1;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {{(M_TDATA_W - ID_W - FLEN_W - BYTE_W){1'b0}},
                            r_o_byte, r_o_len, r_o_id};

    // ---------------- assertions ----------------
    a_committed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_committed <= LEN_W'(REASM_BYTES))
        else $error("reassembly length exceeds store size");

    a_fetch_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fv |-> (r_state == ST_EMIT))
        else $error("RAM fetch outside frame read-out");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_cnt <= r_n))
        else $error("read-out counter passed frame length");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_emit |=> (r_committed == '0) && (r_state == ST_EMIT) && !s_axis_tready)
        else $error("frame start did not clear store and stall input");

endmodule
